// ===== sv/blowfish_block_decrypt_top_defines.svh =====
// ----------------------------------------------------------------------------
// Blowfish block decrypt - assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BLOWFISH_BLOCK_DECRYPT_TOP_DEFINES_SVH
`define BLOWFISH_BLOCK_DECRYPT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Blowfish block decrypt - package
// Field widths, item kinds, table geometry and the round function.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

  localparam int KIND_W = 2;
  localparam int IDX_W  = 10;
  localparam int WORD_W = 32;

  localparam int P_DEPTH   = 18;
  localparam int P_AW      = 5;
  localparam int NUM_BOXES = 4;
  localparam int BOX_AW    = 8;
  localparam int BOX_DEPTH = 256;

  localparam logic [KIND_W-1:0] KIND_DECRYPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_P_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_S_WRITE = 2'd2;

  localparam logic [IDX_W-1:0] P_DEPTH_IDX = 10'd18;
  localparam logic [P_AW-1:0]  P_FIRST     = 5'd17;
  localparam logic [P_AW-1:0]  CNT_START   = 5'd16;
  localparam logic [P_AW-1:0]  CNT_LAST    = 5'd0;

  typedef struct packed {
    logic              en;
    logic [P_AW-1:0]   addr;
    logic [WORD_W-1:0] data;
  } pmem_wr_t;

  typedef struct packed {
    logic              en;
    logic [BOX_AW-1:0] addr;
    logic [WORD_W-1:0] data;
  } sbox_wr_t;

  // F = ((S0[a] + S1[b]) ^ S2[c]) + S3[d], all modulo 2^32
  function automatic logic [WORD_W-1:0] bfd_f(input logic [WORD_W-1:0] s0,
                                                input logic [WORD_W-1:0] s1,
                                                input logic [WORD_W-1:0] s2,
                                                input logic [WORD_W-1:0] s3);
    return ((s0 + s1) ^ s2) + s3;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bfd_if.sv =====
// ----------------------------------------------------------------------------
// Blowfish block decrypt - channel interfaces
// Valid/ready channels for input items and decrypted blocks.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfd_in_if;
  import bfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  table_index;
  logic [WORD_W-1:0] table_word;
  logic [WORD_W-1:0] left_half;
  logic [WORD_W-1:0] right_half;

  modport source (output valid, kind, table_index, table_word, left_half, right_half,
                  input ready);
  modport sink (input valid, kind, table_index, table_word, left_half, right_half,
                output ready);
endinterface

interface bfd_out_if;
  import bfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] left_out;
  logic [WORD_W-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

// ===== sv/bfd_pmem.sv =====
// ----------------------------------------------------------------------------
// Blowfish block decrypt - P-array memory
// 18 x 32 synchronous memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_pmem (
  input  wire logic                    clk,
  input  wire bfd_pkg::pmem_wr_t       wr,
  input  wire logic [bfd_pkg::P_AW-1:0] rd_addr,
  output logic [bfd_pkg::WORD_W-1:0]   rd_data
);
  import bfd_pkg::*;

  logic [WORD_W-1:0] mem [P_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== sv/bfd_sbox_bank.sv =====
// ----------------------------------------------------------------------------
// Blowfish block decrypt - S-box bank
// One 256 x 32 S-box, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_sbox_bank (
  input  wire logic                       clk,
  input  wire bfd_pkg::sbox_wr_t          wr,
  input  wire logic [bfd_pkg::BOX_AW-1:0] rd_addr,
  output logic [bfd_pkg::WORD_W-1:0]      rd_data
);
  import bfd_pkg::*;

  logic [WORD_W-1:0] mem [BOX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== sv/blowfish_block_decrypt_top.sv =====
// ----------------------------------------------------------------------------
// Blowfish block decrypt - top level
// Usage:
//   in_chan carries one item per transaction: kind selects a block decrypt,
//   a P-array write (index 0..17, larger indexes dropped) or an S-box write
//   (index = box*256 + byte). Kind 3 is dropped. Load every P and S entry
//   before the first decrypt; table writes produce no output transaction.
//   out_chan carries left_out/right_out, one transaction per decrypt.
//   A table write leaves the block idle. A decrypt occupies the block
//   from acceptance until its final step: a prefetch step mixes in P[17],
//   sixteen rounds follow at one per cycle (P[1] folds into the last), and
//   a final step applies P[0] and loads the output. The round loop is
//   bound by the registered read of the four S-box banks: the next S-box
//   address comes straight from this round's F output. in_chan.ready is
//   high only between decrypts.
//   The output register holds a result until taken; the next item is
//   accepted meanwhile and a decrypt stalls in its final step until the
//   output register frees up.
//   Reset clears control state only; table contents are undefined until
//   written and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "blowfish_block_decrypt_top_defines.svh"

module blowfish_block_decrypt_top (
  input  wire logic clk,
  input  wire logic rst_n,
  bfd_in_if.sink    in_chan,
  bfd_out_if.source out_chan
);
  import bfd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PRE   = 4'b0010,
    S_ROUND = 4'b0100,
    S_FIN   = 4'b1000
  } bfd_state_t;

  bfd_state_t        state_r, state_nxt;
  logic [P_AW-1:0]   cnt_r, cnt_nxt;
  logic [WORD_W-1:0] x_r, x_nxt;
  logic [WORD_W-1:0] y_r, y_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [WORD_W-1:0] out_left_r, out_right_r;

  logic              in_acc;
  logic              dec_acc;
  logic              fin_load;
  logic [P_AW-1:0]   p_rd_addr;
  logic [WORD_W-1:0] p_q;
  logic [WORD_W-1:0] f_val;
  pmem_wr_t          p_wr;
  sbox_wr_t          s_wr   [NUM_BOXES];
  logic [WORD_W-1:0] s_data [NUM_BOXES];

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign dec_acc       = in_acc && (in_chan.kind == KIND_DECRYPT);
  assign fin_load      = (state_r == S_FIN) && (!out_vld_r || out_chan.ready);

  // Table write ports
  assign p_wr.en   = in_acc && (in_chan.kind == KIND_P_WRITE) &&
                     (in_chan.table_index < P_DEPTH_IDX);
  assign p_wr.addr = in_chan.table_index[P_AW-1:0];
  assign p_wr.data = in_chan.table_word;

  assign p_rd_addr = (state_r == S_IDLE) ? P_FIRST : cnt_r;

  bfd_pmem u_pmem (
    .clk     (clk),
    .wr      (p_wr),
    .rd_addr (p_rd_addr),
    .rd_data (p_q)
  );

  for (genvar b = 0; b < NUM_BOXES; b++) begin : g_box
    assign s_wr[b].en   = in_acc && (in_chan.kind == KIND_S_WRITE) &&
                          (in_chan.table_index[IDX_W-1:BOX_AW] == 2'(b));
    assign s_wr[b].addr = in_chan.table_index[BOX_AW-1:0];
    assign s_wr[b].data = in_chan.table_word;

    // Box 0 takes the most significant byte
    bfd_sbox_bank u_bank (
      .clk     (clk),
      .wr      (s_wr[b]),
      .rd_addr (x_nxt[(NUM_BOXES-1-b)*BOX_AW +: BOX_AW]),
      .rd_data (s_data[b])
    );
  end

  assign f_val = bfd_f(s_data[0], s_data[1], s_data[2], s_data[3]);

  // x holds the F argument of the coming round, y the other half
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    out_vld_nxt = out_vld_r && !out_chan.ready;
    unique case (state_r)
      S_IDLE: begin
        if (dec_acc) begin
          state_nxt = S_PRE;
          cnt_nxt   = CNT_START;
          x_nxt     = in_chan.left_half;
          y_nxt     = in_chan.right_half;
        end
      end
      S_PRE: begin
        state_nxt = S_ROUND;
        cnt_nxt   = cnt_r - 1'b1;
        x_nxt     = x_r ^ p_q;
      end
      S_ROUND: begin
        x_nxt = y_r ^ f_val ^ p_q;
        y_nxt = x_r;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_nxt   = S_IDLE;
          out_vld_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= CNT_LAST;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    // Undo the last swap: y carries the final left half, x the final right
    if (fin_load) begin
      out_left_r  <= y_r ^ p_q;
      out_right_r <= x_r;
    end
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.left_out  = out_left_r;
  assign out_chan.right_out = out_right_r;

  `BFD_ASSERT(a_dec_starts, clk, rst_n, dec_acc |=> (state_r == S_PRE), "decrypt did not start")
  `BFD_ASSERT(a_pre_count, clk, rst_n, (state_r == S_PRE) |-> (cnt_r == CNT_START), "bad round count at prefetch")
  `BFD_ASSERT(a_rounds_end, clk, rst_n, ((state_r == S_ROUND) && (cnt_r == CNT_LAST)) |=> (state_r == S_FIN), "round loop did not end")
  `BFD_ASSERT(a_fin_loads, clk, rst_n, fin_load |=> (out_vld_r && (state_r == S_IDLE)), "result not loaded")

endmodule

`default_nettype wire
